@@ sv/length_prefix_deframer_macros.svh @@
// Assertion macros used by the deframer top level.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lpd_pkg.sv @@
// Shared types, codes and constants of the length-prefixed deframer.
// No dependencies; every other file but the macros header imports this package.
package lpd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned CFG_W       = 12;
	localparam int unsigned LEFT_W      = 12;
	localparam int unsigned KIND_W      = 3;
	localparam int unsigned IDX_W       = 3;
	localparam int unsigned HELLO_BYTES = 5;
	localparam int unsigned MAX_FRAME_DEFAULT = 2048;
	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd2048;

	// Hello tag, one byte per position.
	localparam logic [BYTE_W-1:0] HELLO_TAG [4] = '{8'h52, 8'h45, 8'h54, 8'h48};

	// Result codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_CONSUMED = 3'd0,
		KIND_PAYLOAD  = 3'd1,
		KIND_HELLO_OK = 3'd2,
		KIND_HELLO_NG = 3'd3,
		KIND_BAD_LEN  = 3'd4
	} kind_t;

	// Receive phase, one-hot.
	typedef enum logic [4:0] {
		PH_HELLO   = 5'b00001,
		PH_LEN_HI  = 5'b00010,
		PH_LEN_LO  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_FAILED  = 5'b10000
	} phase_t;

	// Deframer state carried from byte to byte.
	typedef struct packed {
		phase_t            phase;
		logic [IDX_W-1:0]  hello_index;
		logic              hello_mismatch;
		logic [BYTE_W-1:0] length_high;
		logic [LEFT_W-1:0] bytes_left;
		logic              payload_started;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:           PH_HELLO,
		hello_index:     '0,
		hello_mismatch:  1'b0,
		length_high:     '0,
		bytes_left:      '0,
		payload_started: 1'b0
	};

	// One result item.
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] out_byte;
		logic              frame_first;
		logic              frame_last;
		logic [LEN_W-1:0]  bad_length;
	} result_t;

endpackage

@@ sv/lpd_if.sv @@
// Handshake channel interfaces of the deframer: input bytes, results, config writes.
// Depends on lpd_pkg for field widths.
interface lpd_rx_if import lpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              restart;

	modport source (output valid, rx_byte, restart, input ready);
	modport sink (input valid, rx_byte, restart, output ready);
endinterface

interface lpd_tx_if import lpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] out_byte;
	logic              frame_first;
	logic              frame_last;
	logic [LEN_W-1:0]  bad_length;

	modport source (output valid, kind, out_byte, frame_first, frame_last, bad_length,
		input ready);
	modport sink (input valid, kind, out_byte, frame_first, frame_last, bad_length,
		output ready);
endinterface

interface lpd_cfg_if import lpd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/length_prefix_deframer.sv @@
// Length-prefixed deframer top level: hello check, then 2-byte length and payload split.
// A byte accepted on rx passes through the input register and the result register before it is offered on tx.
// Throughput: one byte per cycle while tx is ready; the per-byte state update is one pass of lpd_step.
// A stalled result holds in the result register while one more byte waits in the input register.
// Reset (arst_n low) clears the phase state, the valid flags and sets max_frame_len to 2048.
// Depends on lpd_pkg, lpd_if.sv, lpd_step and length_prefix_deframer_macros.svh.
`include "length_prefix_deframer_macros.svh"

module length_prefix_deframer import lpd_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
) (
	input logic    clk,
	input logic    arst_n,
	lpd_rx_if.sink rx,
	lpd_tx_if.source tx,
	lpd_cfg_if.sink cfg
);

	logic [CFG_W-1:0]  max_len_q;
	state_t            state_q;
	state_t            state_next;
	result_t           result;
	result_t           result_q;
	logic              out_v_q;
	logic              in_v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              restart_s1;
	logic              advance;

	// Configuration register, always ready.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.data;
		end
	end

	// The input stage moves on whenever the result register is free or being drained.
	assign advance  = !out_v_q || tx.ready;
	assign rx.ready = !in_v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (rx.ready) begin
			in_v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1    <= rx.rx_byte;
			restart_s1 <= rx.restart;
		end
	end

	lpd_step #(
		.MAX_FRAME(MAX_FRAME)
	) u_step (
		.state        (state_q),
		.rx_byte      (byte_s1),
		.restart      (restart_s1),
		.max_frame_len(max_len_q),
		.state_next   (state_next),
		.result       (result)
	);

	// Deframer state advances once per byte that reaches the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= in_v_s1;
			if (in_v_s1) begin
				state_q <= state_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance && in_v_s1) begin
			result_q <= result;
		end
	end

	assign tx.valid       = out_v_q;
	assign tx.kind        = result_q.kind;
	assign tx.out_byte    = result_q.out_byte;
	assign tx.frame_first = result_q.frame_first;
	assign tx.frame_last  = result_q.frame_last;
	assign tx.bad_length  = result_q.bad_length;

	// A reported bad length leaves the block failed.
	`LPD_ASSERT_NEXT(a_bad_len_fails, advance && in_v_s1 && result.kind == KIND_BAD_LEN,
		state_q.phase == PH_FAILED, "bad length did not enter failed phase")
	// The last payload byte of a frame hands over to the next length prefix.
	`LPD_ASSERT_NEXT(a_last_to_len, advance && in_v_s1 && result.frame_last,
		state_q.phase == PH_LEN_HI, "frame end did not return to length phase")
	// While in payload at least one byte remains.
	`LPD_ASSERT_NOW(a_left_nonzero, state_q.phase == PH_PAYLOAD, state_q.bytes_left != '0,
		"payload phase with no bytes left")
	// The bad length field is zero for every other kind.
	`LPD_ASSERT_NOW(a_badlen_zero, out_v_q && tx.kind != KIND_BAD_LEN, tx.bad_length == '0,
		"bad length set on a non-error result")

endmodule

@@ sv/lpd_step.sv @@
// Per-byte decision logic: next state and result from current state and one byte.
// Depends on lpd_pkg for the state, result and code types.
module lpd_step import lpd_pkg::*; #(
	parameter int unsigned MAX_FRAME = MAX_FRAME_DEFAULT
) (
	input  state_t            state,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              restart,
	input  logic [CFG_W-1:0]  max_frame_len,
	output state_t            state_next,
	output result_t           result
);

	localparam logic [LEN_W-1:0] FRAME_CAP = LEN_W'(MAX_FRAME);

	state_t           cur;
	logic [LEN_W-1:0] len;
	logic             len_bad;

	// A restart discards state before the byte is looked at.
	assign cur = restart ? STATE_RESET : state;

	// Length check against both the register and the build-time cap.
	assign len     = {cur.length_high, rx_byte};
	assign len_bad = (len == '0) || (len > {{(LEN_W-CFG_W){1'b0}}, max_frame_len})
		|| (len > FRAME_CAP);

	// Phase handling.
	always_comb begin
		state_next = cur;
		result     = '{kind: KIND_CONSUMED, out_byte: '0, frame_first: 1'b0,
			frame_last: 1'b0, bad_length: '0};
		case (cur.phase)
			PH_HELLO: begin
				if (!cur.hello_index[IDX_W-1]) begin
					if (rx_byte != HELLO_TAG[cur.hello_index[1:0]]) begin
						state_next.hello_mismatch = 1'b1;
					end
					state_next.hello_index = cur.hello_index + 1'b1;
				end else begin
					if (cur.hello_mismatch) begin
						result.kind      = KIND_HELLO_NG;
						state_next.phase = PH_FAILED;
					end else begin
						result.kind      = KIND_HELLO_OK;
						result.out_byte  = rx_byte;
						state_next.phase = PH_LEN_HI;
					end
					state_next.hello_index = IDX_W'(HELLO_BYTES);
				end
			end
			PH_LEN_HI: begin
				state_next.length_high = rx_byte;
				state_next.phase       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len_bad) begin
					result.kind       = KIND_BAD_LEN;
					result.bad_length = len;
					state_next.phase  = PH_FAILED;
				end else begin
					// A good length never exceeds the 12-bit register range.
					state_next.bytes_left      = len[LEFT_W-1:0];
					state_next.payload_started = 1'b0;
					state_next.phase           = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				result.kind                = KIND_PAYLOAD;
				result.out_byte            = rx_byte;
				result.frame_first         = !cur.payload_started;
				state_next.payload_started = 1'b1;
				if (cur.bytes_left <= LEFT_W'(1)) begin
					result.frame_last          = 1'b1;
					state_next.bytes_left      = '0;
					state_next.payload_started = 1'b0;
					state_next.phase           = PH_LEN_HI;
				end else begin
					state_next.bytes_left = cur.bytes_left - 1'b1;
				end
			end
			PH_FAILED: begin
				state_next.phase = PH_FAILED;
			end
			default: begin
				state_next.phase = PH_FAILED;
			end
		endcase
	end

endmodule
